/* design/ladp_pkg.sv */
// Shared constants for the linear actuator deadband positioner.
// Holds opcodes, register indexes, reset values and sizing defaults.
// No dependencies.
`default_nettype none

package ladp_pkg;

  // Default field widths
  localparam int ADC_BITS_DEF = 10;
  localparam int POS_BITS_DEF = 12;

  // Opcodes carried in the input tuser
  localparam logic [1:0] OP_SET     = 2'd0;
  localparam logic [1:0] OP_HALT    = 2'd1;
  localparam logic [1:0] OP_REFRESH = 2'd2;

  // Register indexes (byte address / 4)
  localparam logic [1:0] REG_ENABLED  = 2'd0;
  localparam logic [1:0] REG_FULL_IN  = 2'd1;
  localparam logic [1:0] REG_FULL_OUT = 2'd2;
  localparam logic [1:0] REG_THROW    = 2'd3;

  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  // Register reset values, truncated to the configured widths where used
  localparam logic [31:0] FULL_IN_RST  = 32'd963;
  localparam logic [31:0] FULL_OUT_RST = 32'd57;
  localparam logic [31:0] THROW_RST    = 32'd100;

  // Distance at or below which the actuator is considered on target
  localparam int DEADBAND = 3;

endpackage

`default_nettype wire

/* design/ladp_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
// Used by the positioner top level; standalone, no package needed.
`default_nettype none

module ladp_div #(
  parameter int DIVIDEND_W = 22,
  parameter int DIVISOR_W  = 10
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [DIVIDEND_W-1:0] dividend_i,
  input  wire logic [DIVISOR_W-1:0]  divisor_i,
  output logic                       done_o,
  output logic [DIVIDEND_W-1:0]      quotient_o
);

  localparam int CntW = $clog2(DIVIDEND_W + 1);

  logic [DIVIDEND_W-1:0] quo_q, quo_d;
  logic [DIVISOR_W-1:0]  rem_q, rem_d;
  logic [DIVISOR_W-1:0]  dsr_q, dsr_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic                  busy_q, busy_d;
  logic                  done_q, done_d;

  logic [DIVISOR_W:0]    rem_sh;
  logic [DIVISOR_W+1:0]  trial;
  logic                  fits;

  always_comb begin
    rem_sh = {rem_q, quo_q[DIVIDEND_W-1]};
    trial  = {1'b0, rem_sh} - {2'b00, dsr_q};
    fits   = ~trial[DIVISOR_W+1];

    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;

    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
      cnt_d  = CntW'(DIVIDEND_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // shift in the next dividend bit, keep the difference if it fits
      rem_d = fits ? trial[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
      quo_d = {quo_q[DIVIDEND_W-2:0], fits};
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

/* design/linear_actuator_deadband_positioner.sv */
// Sequence: IDLE captures an input transaction, MUL forms the product, DIV runs the divider,
// and DONE writes the output register once it is free. DIV is skipped on equal calibration
// or opposite signs. One item is in flight at a time; the divider yields one quotient bit per
// cycle. The output register lets the next item start early.
// Reset (async, active low): drives, target and moving flag clear; registers take defaults.
// Top level of the positioner; uses ladp_pkg and ladp_div.
`default_nettype none

module linear_actuator_deadband_positioner #(
  parameter int ADC_BITS = ladp_pkg::ADC_BITS_DEF,
  parameter int POS_BITS = ladp_pkg::POS_BITS_DEF,
  localparam int IN_W    = ((POS_BITS + ADC_BITS + 7) / 8) * 8,
  localparam int OUT_W   = ((POS_BITS + 5 + 7) / 8) * 8
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // configuration
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [ladp_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [ladp_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [ladp_pkg::APB_DATA_W-1:0] prdata,
  output logic                                 pready,
  // input stream
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [IN_W-1:0]                 s_axis_tdata,  // target_position, adc_sample
  input  wire logic [1:0]                      s_axis_tuser,  // opcode
  // result stream
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // drive_a, drive_b, move_enable, is_moving, position, calibration_fault
  output logic      [OUT_W-1:0]                m_axis_tdata
);

  localparam int ProdW = ADC_BITS + POS_BITS;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic                enabled_q;
  logic [ADC_BITS-1:0] full_in_q;
  logic [ADC_BITS-1:0] full_out_q;
  logic [POS_BITS-1:0] throw_q;
  logic                cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q  <= 1'b0;
      full_in_q  <= ADC_BITS'(ladp_pkg::FULL_IN_RST);
      full_out_q <= ADC_BITS'(ladp_pkg::FULL_OUT_RST);
      throw_q    <= POS_BITS'(ladp_pkg::THROW_RST);
    end else if (cfg_wr) begin
      case (paddr[3:2])
        ladp_pkg::REG_ENABLED:  enabled_q  <= pwdata[0];
        ladp_pkg::REG_FULL_IN:  full_in_q  <= pwdata[ADC_BITS-1:0];
        ladp_pkg::REG_FULL_OUT: full_out_q <= pwdata[ADC_BITS-1:0];
        ladp_pkg::REG_THROW:    throw_q    <= pwdata[POS_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      ladp_pkg::REG_ENABLED:  prdata = ladp_pkg::APB_DATA_W'(enabled_q);
      ladp_pkg::REG_FULL_IN:  prdata = ladp_pkg::APB_DATA_W'(full_in_q);
      ladp_pkg::REG_FULL_OUT: prdata = ladp_pkg::APB_DATA_W'(full_out_q);
      ladp_pkg::REG_THROW:    prdata = ladp_pkg::APB_DATA_W'(throw_q);
      default:                prdata = '0;
    endcase
  end

  // captured item
  logic [1:0]          op_q;
  logic [POS_BITS-1:0] tgt_q;
  logic [ADC_BITS-1:0] smp_q;
  logic                fault_q, skip_q;

  // control state
  logic [POS_BITS-1:0] held_q, held_d;
  logic                moving_q, moving_d;
  logic                lvl_a_q, lvl_a_d;
  logic                lvl_b_q, lvl_b_d;
  logic                lvl_mv_q, lvl_mv_d;

  logic                out_vld_q, out_vld_d;
  logic [OUT_W-1:0]    out_data_q, out_data_d;

  // mapping arithmetic
  logic [ADC_BITS:0]   num_s, den_s, num_abs, den_abs;
  logic                fault_c, skip_c;
  logic [ProdW-1:0]    product;
  logic                div_start, div_done;
  logic [ProdW-1:0]    quotient;

  always_comb begin
    num_s   = {1'b0, smp_q} - {1'b0, full_in_q};
    den_s   = {1'b0, full_out_q} - {1'b0, full_in_q};
    num_abs = num_s[ADC_BITS] ? (~num_s + 1'b1) : num_s;
    den_abs = den_s[ADC_BITS] ? (~den_s + 1'b1) : den_s;
    fault_c = (den_s == '0);
    // opposite signs give a quotient at or below zero, which clamps to zero
    skip_c  = fault_c || ((num_s[ADC_BITS] != den_s[ADC_BITS]) && (num_s != '0));
    product = num_abs[ADC_BITS-1:0] * throw_q;
  end

  assign div_start = (state_q == ST_MUL) && !skip_c;

  ladp_div #(
    .DIVIDEND_W (ProdW),
    .DIVISOR_W  (ADC_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (product),
    .divisor_i  (den_abs[ADC_BITS-1:0]),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // final decision
  logic [POS_BITS-1:0] pos;
  logic [POS_BITS-1:0] tgt_sel;
  logic [POS_BITS:0]   diff, diff_abs;
  logic                far, act, halt;
  logic                out_free;

  always_comb begin
    if (skip_q) begin
      pos = '0;
    end else if (quotient > ProdW'(throw_q)) begin
      pos = throw_q;
    end else begin
      pos = quotient[POS_BITS-1:0];
    end
    tgt_sel  = (op_q == ladp_pkg::OP_SET) ? tgt_q : held_q;
    diff     = {1'b0, pos} - {1'b0, tgt_sel};
    diff_abs = diff[POS_BITS] ? (~diff + 1'b1) : diff;
    far      = diff_abs > (POS_BITS + 1)'(ladp_pkg::DEADBAND);
    act      = enabled_q && ((op_q == ladp_pkg::OP_SET) ||
                             ((op_q == ladp_pkg::OP_REFRESH) && moving_q));
    halt     = enabled_q && (op_q == ladp_pkg::OP_HALT);
    out_free = !out_vld_q || m_axis_tready;
  end

  always_comb begin
    state_d    = state_q;
    held_d     = held_q;
    moving_d   = moving_q;
    lvl_a_d    = lvl_a_q;
    lvl_b_d    = lvl_b_q;
    lvl_mv_d   = lvl_mv_q;
    out_vld_d  = out_vld_q && !m_axis_tready;
    out_data_d = out_data_q;

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) state_d = ST_MUL;
      end
      ST_MUL: begin
        state_d = skip_c ? ST_DONE : ST_DIV;
      end
      ST_DIV: begin
        if (div_done) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          if (act && far) begin
            held_d   = tgt_sel;
            moving_d = 1'b1;
            // position above target: drive a; target above position: drive b
            lvl_a_d  = ~diff[POS_BITS];
            lvl_b_d  = diff[POS_BITS];
            lvl_mv_d = 1'b1;
          end else if (act || halt) begin
            moving_d = 1'b0;
            lvl_a_d  = 1'b0;
            lvl_b_d  = 1'b0;
            lvl_mv_d = 1'b0;
          end
          out_vld_d  = 1'b1;
          out_data_d = OUT_W'({fault_q, pos, moving_d, lvl_mv_d, lvl_b_d, lvl_a_d});
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      held_q    <= '0;
      moving_q  <= 1'b0;
      lvl_a_q   <= 1'b0;
      lvl_b_q   <= 1'b0;
      lvl_mv_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      held_q    <= held_d;
      moving_q  <= moving_d;
      lvl_a_q   <= lvl_a_d;
      lvl_b_q   <= lvl_b_d;
      lvl_mv_q  <= lvl_mv_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    if (state_q == ST_IDLE && s_axis_tvalid) begin
      op_q  <= s_axis_tuser;
      tgt_q <= s_axis_tdata[POS_BITS-1:0];
      smp_q <= s_axis_tdata[POS_BITS+ADC_BITS-1:POS_BITS];
    end
    if (state_q == ST_MUL) begin
      fault_q <= fault_c;
      skip_q  <= skip_c;
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

  // one item in flight: no new transaction right after an accepted one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted twice in a row");

  // reported position stays within the travel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[POS_BITS+3:4] <= throw_q))
    else $error("position beyond throw length");

  // calibration fault forces position zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[POS_BITS+4] |-> (m_axis_tdata[POS_BITS+3:4] == '0))
    else $error("fault with nonzero position");

  // move enable matches tracking, and exactly one bridge input is high while moving
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lvl_mv_q == moving_q) && (lvl_mv_q == (lvl_a_q ^ lvl_b_q)) && !(lvl_a_q && lvl_b_q))
    else $error("drive levels inconsistent with moving flag");

  // the divider finishes only while the sequencer waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV))
    else $error("divider done outside divide state");

endmodule

`default_nettype wire
